### hw/rtl/veg_pkg.sv
`default_nettype none

package veg_pkg;

  localparam int MAX_BLOCK  = 1024;
  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int CNT_W      = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W      = SQ_W + CNT_W - 2;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
  localparam int THR_W      = 31;
  localparam int MEAN_W     = 31;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HANG_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_UTTER = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 31'd1073741824;
  localparam logic [TIME_W-1:0] HANG_TIME_RST = 32'd500;
  localparam logic [TIME_W-1:0] MAX_UTTER_RST = 32'd10000;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ACC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_GATE = 5'b10000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic square;
    logic accum;
    logic div_step;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic blk_end;
    logic div_done;
    logic out_free;
    logic is_open;
    logic needs_quiet;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/veg_ctrl.sv
`default_nettype none

module veg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  veg_pkg::status_t     st,
  output veg_pkg::cmd_t        cmd
);
  import veg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.square = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = st.blk_end ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (st.div_done) begin
          state_nxt = S_GATE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_GATE: begin
        // wait for room in the output register
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/veg_dp.sv
`default_nettype none

module veg_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic signed [veg_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic                                  in_last_in_block,
  input  wire logic        [veg_pkg::TIME_W-1:0]     in_now_time,
  input  wire logic                                  cfg_wr,
  input  wire logic        [veg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [veg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  veg_pkg::cmd_t                              cmd,
  output veg_pkg::status_t                           st,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_gate_open,
  output logic             [veg_pkg::MEAN_W-1:0]     out_mean_square
);
  import veg_pkg::*;

  // configuration
  logic [THR_W-1:0]  thr_r;
  logic [TIME_W-1:0] hang_r;
  logic [TIME_W-1:0] max_r;

  // input capture and square
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       last_r;
  logic [TIME_W-1:0]          now_r;
  logic [SAMPLE_W-1:0]        mag;
  logic [SQ_W-1:0]            sq_r;

  // accumulator; shifts into the quotient during division
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       trial_sub;
  logic                 trial_ge;

  // gate state
  logic              open_r, open_nxt;
  logic              nq_r, nq_nxt;
  logic [TIME_W-1:0] open_time_r, open_time_nxt;
  logic [TIME_W-1:0] lv_time_r, lv_time_nxt;
  logic [TIME_W-1:0] d_open;
  logic [TIME_W-1:0] d_voice;
  logic              voiced;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_gate_r;
  logic [MEAN_W-1:0] out_mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RST;
      hang_r <= HANG_TIME_RST;
      max_r  <= MAX_UTTER_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
        REG_HANG_TIME: hang_r <= cfg_data[TIME_W-1:0];
        REG_MAX_UTTER: max_r  <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
      last_r   <= in_last_in_block;
      now_r    <= in_now_time;
    end
    if (cmd.square) begin
      sq_r <= mag * mag;
    end
  end

  // two's complement negate of the most negative value gives 0x8000, as wanted
  assign mag = sample_r[SAMPLE_W-1] ? SAMPLE_W'(-sample_r) : SAMPLE_W'(sample_r);

  // restoring division, one quotient bit per cycle
  assign trial     = {rem_r, sum_r[SUM_W-1]};
  assign trial_ge  = (trial >= {1'b0, cnt_r});
  assign trial_sub = trial - {1'b0, cnt_r};

  assign voiced  = (sum_r >= SUM_W'(thr_r));
  assign d_open  = now_r - open_time_r;
  assign d_voice = now_r - lv_time_r;

  always_comb begin
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    open_nxt      = open_r;
    nq_nxt        = nq_r;
    open_time_nxt = open_time_r;
    lv_time_nxt   = lv_time_r;
    out_valid_nxt = out_valid_r & out_stall;

    if (cmd.accum) begin
      sum_nxt     = sum_r + SUM_W'(sq_r);
      cnt_nxt     = cnt_r + CNT_W'(1);
      rem_nxt     = '0;
      div_cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      sum_nxt     = {sum_r[SUM_W-2:0], trial_ge};
      rem_nxt     = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
    end

    if (cmd.finish) begin
      if (open_r) begin
        if (voiced) begin
          lv_time_nxt = now_r;
        end
        // cap takes priority over hang
        if (d_open >= max_r) begin
          open_nxt      = 1'b0;
          nq_nxt        = 1'b1;
          open_time_nxt = '0;
        end else if (!voiced && (d_voice >= hang_r)) begin
          open_nxt      = 1'b0;
          open_time_nxt = '0;
        end
      end else if (nq_r) begin
        if (!voiced) begin
          nq_nxt = 1'b0;
        end
      end else if (voiced) begin
        open_nxt      = 1'b1;
        open_time_nxt = now_r;
        lv_time_nxt   = now_r;
      end
      sum_nxt       = '0;
      cnt_nxt       = '0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      open_r      <= 1'b0;
      nq_r        <= 1'b0;
      open_time_r <= '0;
      lv_time_r   <= '0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      open_r      <= open_nxt;
      nq_r        <= nq_nxt;
      open_time_r <= open_time_nxt;
      lv_time_r   <= lv_time_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (cmd.finish) begin
      out_gate_r <= open_nxt;
      out_mean_r <= sum_r[MEAN_W-1:0];
    end
  end

  assign st.blk_end     = last_r || (cnt_r == CNT_W'(MAX_BLOCK - 1));
  assign st.div_done    = (div_cnt_r == DIV_CNT_W'(SUM_W));
  assign st.out_free    = !out_valid_r || !out_stall;
  assign st.is_open     = open_r;
  assign st.needs_quiet = nq_r;

  assign out_valid       = out_valid_r;
  assign out_gate_open   = out_gate_r;
  assign out_mean_square = out_mean_r;

endmodule

`default_nettype wire

### hw/rtl/vox_energy_gate.sv
// Each sample is loaded, squared and accumulated; in_stall holds off the next sample.
// A block-end sample then goes through the bit-serial divider (one quotient bit per
// cycle over the 41-bit energy sum) and the gate decision, which registers the result.
// A waiting result does not block input; only the next block end waits for the output.
// Reset (rst_n low, synchronous): gate closed and armed, sums and counts cleared,
// registers back to defaults (threshold 2^30, hang 500 ms, max utterance 10000 ms).
`default_nettype none

module vox_energy_gate (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [veg_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic                                  in_last_in_block,
  input  wire logic        [veg_pkg::TIME_W-1:0]     in_now_time,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_gate_open,
  output logic             [veg_pkg::MEAN_W-1:0]     out_mean_square,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic        [veg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [veg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import veg_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  veg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  veg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_sample        (in_sample),
    .in_last_in_block (in_last_in_block),
    .in_now_time      (in_now_time),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_gate_open    (out_gate_open),
    .out_mean_square  (out_mean_square)
  );

`ifndef SYNTHESIS
  a_finish_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> st.out_free)
    else $error("block result written while output register is occupied");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result appeared without a block decision");

  a_open_excl_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !(st.is_open && st.needs_quiet))
    else $error("gate open while a quiet block is still required");
`endif

endmodule

`default_nettype wire
